// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the queue controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/spq_pkg.sv =====
// types and constants of the sorted insert priority queue
package spq_pkg;

  localparam logic [4:0]  DAY_MAX      = 5'd31;
  localparam logic [3:0]  MONTH_MAX    = 4'd12;
  localparam logic [11:0] YEAR_MIN_RST = 12'd1900;
  localparam logic [11:0] YEAR_MAX_RST = 12'd2025;

  typedef enum logic {
    CFG_MIN_YEAR = 1'b0,
    CFG_MAX_YEAR = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_LIST   = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    STAT_INSERTED = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_BAD_DATE = 3'd2,
    STAT_LISTED   = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_LIST
  } state_e;

  typedef struct packed {
    logic [3:0]  sev;
    logic [31:0] tag;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } rec_t;

  typedef struct packed {
    logic       valid;
    status_e    status;
    logic [3:0] position;
    rec_t       rec;
    logic       last;
  } res_t;

endpackage

// ===== rtl/core/spq_mem.sv =====
// record memory, one write and one registered read port
module spq_mem #(
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  spq_pkg::rec_t            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output spq_pkg::rec_t            rdata_o
);

  spq_pkg::rec_t mem [DEPTH];
  spq_pkg::rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/spq_ctrl.sv =====
// sequencer for insert shifting and list streaming over the record memory
`include "assert_macros.svh"

module spq_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     action_i,
  input  spq_pkg::rec_t            rec_i,
  input  logic                     date_ok_i,
  output logic                     busy_o,
  output logic                     ram_we_o,
  output logic [$clog2(DEPTH)-1:0] ram_waddr_o,
  output spq_pkg::rec_t            ram_wdata_o,
  output logic                     ram_re_o,
  output logic [$clog2(DEPTH)-1:0] ram_raddr_o,
  input  spq_pkg::rec_t            ram_rdata_i,
  output spq_pkg::res_t            res_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  spq_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  spq_pkg::rec_t   rec_q, rec_d;
  spq_pkg::res_t   res_q, res_d;

  logic is_list, is_full, is_empty, moves_down, at_head, list_last;

  assign is_list    = (action_i == spq_pkg::ACT_LIST);
  assign is_full    = (count_q == CW'(DEPTH));
  assign is_empty   = (count_q == '0);
  assign moves_down = (rec_q.sev > ram_rdata_i.sev);
  assign at_head    = (ptr_q == AW'(1));
  assign list_last  = ((CW'(ptr_q) + CW'(1)) == count_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spq_pkg::ST_IDLE: begin
        if (start_i) begin
          if (is_list) begin
            if (!is_empty) state_d = spq_pkg::ST_LIST;
          end else if (!is_full && date_ok_i && !is_empty) begin
            state_d = spq_pkg::ST_SHIFT;
          end
        end
      end
      spq_pkg::ST_SHIFT: begin
        if (!moves_down) state_d = spq_pkg::ST_IDLE;
        else if (at_head) state_d = spq_pkg::ST_PLACE;
      end
      spq_pkg::ST_PLACE: begin
        state_d = spq_pkg::ST_IDLE;
      end
      spq_pkg::ST_LIST: begin
        if (list_last) state_d = spq_pkg::ST_IDLE;
      end
      default: state_d = spq_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_d        = count_q;
    ptr_d          = ptr_q;
    rec_d          = rec_q;
    ram_we_o       = 1'b0;
    ram_waddr_o    = ptr_q;
    ram_wdata_o    = rec_q;
    ram_re_o       = 1'b0;
    ram_raddr_o    = ptr_q;
    res_d          = '0;
    res_d.status   = spq_pkg::STAT_INSERTED;
    unique case (state_q)
      spq_pkg::ST_IDLE: begin
        if (start_i) begin
          res_d.last = 1'b1;
          if (is_list) begin
            if (is_empty) begin
              res_d.valid  = 1'b1;
              res_d.status = spq_pkg::STAT_EMPTY;
            end else begin
              ram_re_o    = 1'b1;
              ram_raddr_o = '0;
              ptr_d       = '0;
            end
          end else if (is_full) begin
            res_d.valid  = 1'b1;
            res_d.status = spq_pkg::STAT_FULL;
          end else if (!date_ok_i) begin
            res_d.valid  = 1'b1;
            res_d.status = spq_pkg::STAT_BAD_DATE;
          end else if (is_empty) begin
            // first record goes straight to the head
            ram_we_o    = 1'b1;
            ram_waddr_o = '0;
            ram_wdata_o = rec_i;
            count_d     = count_q + CW'(1);
            res_d.valid = 1'b1;
            res_d.rec   = rec_i;
          end else begin
            // start scanning from the tail
            rec_d       = rec_i;
            ram_re_o    = 1'b1;
            ram_raddr_o = AW'(count_q - CW'(1));
            ptr_d       = AW'(count_q);
          end
        end
      end
      spq_pkg::ST_SHIFT: begin
        ram_we_o = 1'b1;
        if (moves_down) begin
          ram_wdata_o = ram_rdata_i;
          ptr_d       = ptr_q - AW'(1);
          if (!at_head) begin
            ram_re_o    = 1'b1;
            ram_raddr_o = ptr_q - AW'(2);
          end
        end else begin
          count_d        = count_q + CW'(1);
          res_d.valid    = 1'b1;
          res_d.position = 4'(ptr_q);
          res_d.rec      = rec_q;
          res_d.last     = 1'b1;
        end
      end
      spq_pkg::ST_PLACE: begin
        ram_we_o       = 1'b1;
        count_d        = count_q + CW'(1);
        res_d.valid    = 1'b1;
        res_d.position = 4'(ptr_q);
        res_d.rec      = rec_q;
        res_d.last     = 1'b1;
      end
      spq_pkg::ST_LIST: begin
        res_d.valid    = 1'b1;
        res_d.status   = spq_pkg::STAT_LISTED;
        res_d.position = 4'(ptr_q);
        res_d.rec      = ram_rdata_i;
        res_d.last     = list_last;
        if (!list_last) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = ptr_q + AW'(1);
          ptr_d       = ptr_q + AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::ST_IDLE;
      count_q <= '0;
      ptr_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign busy_o = (state_q != spq_pkg::ST_IDLE);
  assign res_o  = res_q;

  `ASSERT_ALWAYS(a_count_bound, count_q <= CW'(DEPTH), "entry count above depth")
  `ASSERT_IMPL(a_no_rw_clash, ram_we_o && ram_re_o, ram_waddr_o != ram_raddr_o, "read and write hit one entry")
  `ASSERT_IMPL(a_shift_not_head, state_q == spq_pkg::ST_SHIFT, ptr_q != '0, "shift step at head")
  `ASSERT_NEXT(a_list_ends, state_q == spq_pkg::ST_LIST && list_last, state_q == spq_pkg::ST_IDLE, "list did not end on last entry")

endmodule

// ===== rtl/core/sorted_insert_priority_queue.sv =====
// top level of the sorted insert priority queue
// A bounded queue of up to DEPTH records kept in one memory, sorted by severity
// with the highest first and equal severities in arrival order. A command is
// taken when start is high and busy is low; results come back one per cycle on
// res_valid_o, which cannot be held off, so sample it every cycle. The result
// of a command appears the cycle after its last step. A rejected insert (full
// queue, bad date) or a list of an empty queue gives one result straight from
// idle. An accepted insert into an empty queue writes the record straight to
// the head; otherwise it fetches the tail, moves down each stored record it
// passes and then places the new record. A list of n records streams n results
// back to back. The steps follow from the single read and single write port of
// the record memory: one record is moved or read per cycle. The memory needs no
// clearing pass after reset; only entries below the fill count are ever read.
module sorted_insert_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [3:0]  severity_i,
  input  logic [31:0] item_tag_i,
  input  logic [4:0]  birth_day_i,
  input  logic [3:0]  birth_month_i,
  input  logic [11:0] birth_year_i,
  // configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [11:0] cfg_data_i,
  // result channel
  output logic        res_valid_o,
  output logic [2:0]  status_o,
  output logic [3:0]  position_o,
  output logic [3:0]  severity_res_o,
  output logic [31:0] item_tag_res_o,
  output logic [4:0]  birth_day_res_o,
  output logic [3:0]  birth_month_res_o,
  output logic [11:0] birth_year_res_o,
  output logic        last_o
);

  localparam int AW = $clog2(DEPTH);

  logic [11:0] min_year_q, min_year_d;
  logic [11:0] max_year_q, max_year_d;

  spq_pkg::rec_t rec_in;
  spq_pkg::rec_t ram_wdata, ram_rdata;
  spq_pkg::res_t res;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic          date_ok;
  logic          cmd_xfer;

  // configuration writes are always taken, one per cycle
  assign cfg_ready_o = 1'b1;

  always_comb begin
    min_year_d = min_year_q;
    max_year_d = max_year_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        spq_pkg::CFG_MIN_YEAR: min_year_d = cfg_data_i;
        spq_pkg::CFG_MAX_YEAR: max_year_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_year_q <= spq_pkg::YEAR_MIN_RST;
      max_year_q <= spq_pkg::YEAR_MAX_RST;
    end else begin
      min_year_q <= min_year_d;
      max_year_q <= max_year_d;
    end
  end

  // incoming record
  assign rec_in = '{
    sev:   severity_i,
    tag:   item_tag_i,
    day:   birth_day_i,
    month: birth_month_i,
    year:  birth_year_i
  };

  // birth date check; inverted year limits reject every year
  assign date_ok = (birth_day_i != '0) && (birth_day_i <= spq_pkg::DAY_MAX)
                && (birth_month_i != '0) && (birth_month_i <= spq_pkg::MONTH_MAX)
                && (birth_year_i >= min_year_q) && (birth_year_i <= max_year_q);

  // a command transfer happens only while idle
  assign cmd_xfer = start && !busy;

  spq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_xfer),
    .action_i   (action_i),
    .rec_i      (rec_in),
    .date_ok_i  (date_ok),
    .busy_o     (busy),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .res_o      (res)
  );

  spq_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // result fields straight from the registered result
  assign res_valid_o       = res.valid;
  assign status_o          = res.status;
  assign position_o        = res.position;
  assign severity_res_o    = res.rec.sev;
  assign item_tag_res_o    = res.rec.tag;
  assign birth_day_res_o   = res.rec.day;
  assign birth_month_res_o = res.rec.month;
  assign birth_year_res_o  = res.rec.year;
  assign last_o            = res.last;

endmodule
